@@ hdl/bcs_pkg.sv @@
// Package for the bilinear crop scaler.
// Holds beat types, register indexes and fixed widths; no dependencies.
`default_nettype none
package bcs_pkg;

	typedef struct packed {
		logic        mode;
		logic [15:0] load_address;
		logic [7:0]  load_value;
		logic [11:0] out_x;
		logic [11:0] out_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic       outside_source;
	} out_item_t;

	typedef struct packed {
		logic [12:0] source_width;
		logic [12:0] source_height;
		logic [11:0] crop_left;
		logic [11:0] crop_top;
		logic [27:0] x_step;
		logic [27:0] y_step;
		logic        color_mode;
	} cfg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd6;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int POS_W = 28;

	localparam logic [MUL_B_W-1:0] FRAC_ONE = 17'h10000;

endpackage
`default_nettype wire

@@ hdl/bcs_mul.sv @@
// Shared multiplier with a registered product.
// Depends on bcs_pkg for the operand widths.
`default_nettype none
module bcs_mul
	import bcs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [MUL_A_W-1:0] op_a,
	input  wire logic [MUL_B_W-1:0] op_b,
	output logic      [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

@@ hdl/bcs_store.sv @@
// Single-port source byte store with registered read data.
// No package dependency; depth set by STORE_BYTES.
`default_nettype none
module bcs_store #(
	parameter int STORE_BYTES = 65536
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(STORE_BYTES)-1:0] addr,
	input  wire logic [7:0]                     wdata,
	output logic      [7:0]                     rdata
);

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hdl/bcs_ctrl.sv @@
// Sequencer and datapath registers for position mapping and blending.
// Depends on bcs_pkg; drives the shared multiplier and the byte store.
`default_nettype none
module bcs_ctrl
	import bcs_pkg::*;
#(
	parameter int STORE_BYTES = 65536
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cfg_t                           cfg,
	input  wire logic                           start,
	input  wire in_item_t                       item,
	output logic                                busy,
	output logic                                done,
	output out_item_t                           result,
	output logic      [MUL_A_W-1:0]             op_a,
	output logic      [MUL_B_W-1:0]             op_b,
	input  wire logic [MUL_P_W-1:0]             prod,
	output logic                                st_we,
	output logic      [$clog2(STORE_BYTES)-1:0] st_addr,
	output logic      [7:0]                     st_wdata,
	input  wire logic [7:0]                     st_rdata
);

	localparam int AW = $clog2(STORE_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MX   = 4'd1;
	localparam logic [3:0] S_MY   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_ROW0 = 4'd4;
	localparam logic [3:0] S_ROW1 = 4'd5;
	localparam logic [3:0] S_ADR  = 4'd6;
	localparam logic [3:0] S_LIM  = 4'd7;
	localparam logic [3:0] S_RA   = 4'd8;
	localparam logic [3:0] S_RB   = 4'd9;
	localparam logic [3:0] S_RC   = 4'd10;
	localparam logic [3:0] S_RD   = 4'd11;
	localparam logic [3:0] S_RE   = 4'd12;
	localparam logic [3:0] S_RF   = 4'd13;
	localparam logic [3:0] S_RG   = 4'd14;
	localparam logic [3:0] S_RH   = 4'd15;

	function automatic logic [POS_W-1:0] times_chans(input logic [25:0] v, input logic rgb);
		logic [POS_W-1:0] ext;
		ext = POS_W'(v);
		return rgb ? ((ext << 1) + ext) : ext;
	endfunction

	logic [3:0]       state_q;
	logic             done_q;
	out_item_t        res_q;
	logic [11:0]      ox_q;
	logic [11:0]      oy_q;
	logic [24:0]      ix_q;
	logic [15:0]      fx_q;
	logic [12:0]      iy_q;
	logic [15:0]      fy_q;
	logic [12:0]      ixn_q;
	logic [12:0]      iyn_q;
	logic [POS_W-1:0] pa_q;
	logic [POS_W-1:0] pb_q;
	logic [POS_W-1:0] pc_q;
	logic [POS_W-1:0] pd_q;
	logic [1:0]       ch_q;
	logic [39:0]      acc_q;
	logic [23:0]      top_q;
	logic [23:0]      bot_q;
	logic [7:0]       c0_q;
	logic [7:0]       c1_q;
	logic [7:0]       c2_q;

	logic             accept;
	logic             do_request;
	logic [40:0]      px;
	logic [40:0]      py;
	logic [24:0]      iy_w;
	logic             outside;
	logic [13:0]      ix_inc;
	logic [13:0]      iy_inc;
	logic [12:0]      ixn_w;
	logic [12:0]      iyn_w;
	logic [1:0]       last_ch;
	logic             beyond_store;
	logic [39:0]      sum;
	logic [7:0]       ch_val;
	logic [MUL_B_W-1:0] one_fx;
	logic [MUL_B_W-1:0] one_fy;
	logic [POS_W-1:0] rd_base;
	logic [POS_W-1:0] rd_pos;
	logic             final_ch;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign do_request = accept && (item.mode == MODE_REQUEST);

	assign px     = 41'(prod[39:0]) + {13'd0, cfg.crop_left, 16'd0};
	assign py     = 41'(prod[39:0]) + {13'd0, cfg.crop_top, 16'd0};
	assign iy_w   = py[40:16];
	assign outside = (ix_q >= 25'(cfg.source_width)) || (iy_w >= 25'(cfg.source_height));
	assign ix_inc = {1'b0, ix_q[12:0]} + 14'd1;
	assign iy_inc = {1'b0, iy_w[12:0]} + 14'd1;
	assign ixn_w  = (ix_inc < {1'b0, cfg.source_width}) ? ix_inc[12:0]
		: cfg.source_width - 13'd1;
	assign iyn_w  = (iy_inc < {1'b0, cfg.source_height}) ? iy_inc[12:0]
		: cfg.source_height - 13'd1;

	assign last_ch      = cfg.color_mode ? 2'd2 : 2'd0;
	assign beyond_store = ({1'b0, pd_q} + 29'(last_ch)) >= 29'(STORE_BYTES);
	assign final_ch     = (ch_q == last_ch);

	assign one_fx = FRAC_ONE - {1'b0, fx_q};
	assign one_fy = FRAC_ONE - {1'b0, fy_q};
	assign sum    = acc_q + prod[39:0];
	assign ch_val = sum[39:32];

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_MX: begin
				op_a = cfg.x_step;
				op_b = MUL_B_W'(ox_q);
			end
			S_MY: begin
				op_a = cfg.y_step;
				op_b = MUL_B_W'(oy_q);
			end
			S_ROW0: begin
				op_a = MUL_A_W'(iy_q);
				op_b = MUL_B_W'(cfg.source_width);
			end
			S_ROW1: begin
				op_a = MUL_A_W'(iyn_q);
				op_b = MUL_B_W'(cfg.source_width);
			end
			S_RB, S_RD: begin
				op_a = MUL_A_W'(st_rdata);
				op_b = one_fx;
			end
			S_RC, S_RE: begin
				op_a = MUL_A_W'(st_rdata);
				op_b = {1'b0, fx_q};
			end
			S_RF: begin
				op_a = MUL_A_W'(top_q);
				op_b = one_fy;
			end
			S_RG: begin
				op_a = MUL_A_W'(bot_q);
				op_b = {1'b0, fy_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_RB:    rd_base = pb_q;
			S_RC:    rd_base = pc_q;
			S_RD:    rd_base = pd_q;
			default: rd_base = pa_q;
		endcase
	end

	assign rd_pos   = rd_base + POS_W'(ch_q);
	assign st_we    = accept && (item.mode == MODE_LOAD)
		&& (32'(item.load_address) < STORE_BYTES);
	assign st_addr  = st_we ? AW'(item.load_address) : AW'(rd_pos);
	assign st_wdata = item.load_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (do_request) begin
						state_q <= S_MX;
					end
				end
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_CHK;
				S_CHK: begin
					if (outside) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_ROW0;
					end
				end
				S_ROW0: state_q <= S_ROW1;
				S_ROW1: state_q <= S_ADR;
				S_ADR:  state_q <= S_LIM;
				S_LIM: begin
					if (beyond_store) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_RA;
					end
				end
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_RC;
				S_RC:   state_q <= S_RD;
				S_RD:   state_q <= S_RE;
				S_RE:   state_q <= S_RF;
				S_RF:   state_q <= S_RG;
				S_RG:   state_q <= S_RH;
				S_RH: begin
					if (final_ch) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_RA;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ox_q <= item.out_x;
				oy_q <= item.out_y;
				c0_q <= 8'd0;
				c1_q <= 8'd0;
				c2_q <= 8'd0;
			end
			S_MY: begin
				ix_q <= px[40:16];
				fx_q <= px[15:0];
			end
			S_CHK: begin
				iy_q  <= iy_w[12:0];
				fy_q  <= py[15:0];
				ixn_q <= ixn_w;
				iyn_q <= iyn_w;
				res_q.chan0          <= 8'd0;
				res_q.chan1          <= 8'd0;
				res_q.chan2          <= 8'd0;
				res_q.outside_source <= 1'b1;
			end
			S_ADR: begin
				pc_q <= times_chans(prod[25:0] + 26'(ix_q[12:0]), cfg.color_mode);
				pd_q <= times_chans(prod[25:0] + 26'(ixn_q), cfg.color_mode);
			end
			S_ROW1: begin
				pa_q <= times_chans(prod[25:0] + 26'(ix_q[12:0]), cfg.color_mode);
				pb_q <= times_chans(prod[25:0] + 26'(ixn_q), cfg.color_mode);
			end
			S_LIM: begin
				ch_q <= 2'd0;
			end
			S_RC, S_RE: begin
				acc_q <= prod[39:0];
			end
			S_RD: begin
				top_q <= sum[23:0];
			end
			S_RF: begin
				bot_q <= sum[23:0];
			end
			S_RG: begin
				acc_q <= prod[39:0];
			end
			S_RH: begin
				unique case (ch_q)
					2'd0:    c0_q <= ch_val;
					2'd1:    c1_q <= ch_val;
					default: c2_q <= ch_val;
				endcase
				ch_q                 <= ch_q + 2'd1;
				res_q.chan0          <= (ch_q == 2'd0) ? ch_val : c0_q;
				res_q.chan1          <= (ch_q == 2'd1) ? ch_val : c1_q;
				res_q.chan2          <= (ch_q == 2'd2) ? ch_val : c2_q;
				res_q.outside_source <= 1'b0;
			end
			default: begin
				ch_q <= ch_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

@@ hdl/bilinear_crop_scaler_unit.sv @@
// Top level of the bilinear crop scaler: configuration registers and instances.
// Depends on bcs_pkg, bcs_mul, bcs_store and bcs_ctrl.
//
// Channel   Ports                      Beat taken when
// input     start, busy, item          start high and busy low
// result    done, result               done high (one cycle, no stall)
// config    wr_en, wr_index, wr_data   wr_en high
//
// A load beat is written to the store directly and busy stays low.
// A request maps x then y and ends when the base lies outside the source or
// the store limit is hit; else it reads four bytes per channel and blends them
// (one channel gray, three RGB) on the shared multiplier and single store port.
// Reset clears the sequencer and loads register defaults; the store is not cleared.
// The receiver cannot stall, so a result is shown for exactly one cycle.
`default_nettype none
module bilinear_crop_scaler_unit
	import bcs_pkg::*;
#(
	parameter int STORE_BYTES = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire in_item_t              item,
	output logic                       done,
	output out_item_t                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t                     cfg_q;
	logic [MUL_A_W-1:0]       op_a;
	logic [MUL_B_W-1:0]       op_b;
	logic [MUL_P_W-1:0]       prod;
	logic                     st_we;
	logic [$clog2(STORE_BYTES)-1:0] st_addr;
	logic [7:0]               st_wdata;
	logic [7:0]               st_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width  <= 13'd64;
			cfg_q.source_height <= 13'd64;
			cfg_q.crop_left     <= 12'd0;
			cfg_q.crop_top      <= 12'd0;
			cfg_q.x_step        <= 28'd65536;
			cfg_q.y_step        <= 28'd65536;
			cfg_q.color_mode    <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SOURCE_WIDTH:  cfg_q.source_width  <= wr_data[12:0];
				REG_SOURCE_HEIGHT: cfg_q.source_height <= wr_data[12:0];
				REG_CROP_LEFT:     cfg_q.crop_left     <= wr_data[11:0];
				REG_CROP_TOP:      cfg_q.crop_top      <= wr_data[11:0];
				REG_X_STEP:        cfg_q.x_step        <= wr_data;
				REG_Y_STEP:        cfg_q.y_step        <= wr_data;
				REG_COLOR_MODE:    cfg_q.color_mode    <= wr_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	bcs_mul u_mul (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	bcs_store #(
		.STORE_BYTES (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	bcs_ctrl #(
		.STORE_BYTES (STORE_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.op_a     (op_a),
		.op_b     (op_b),
		.prod     (prod),
		.st_we    (st_we),
		.st_addr  (st_addr),
		.st_wdata (st_wdata),
		.st_rdata (st_rdata)
	);

endmodule
`default_nettype wire
